// ===== rtl/led_breathe_generator_core_defines.svh =====
// Assertion macros for the breathing LED generator.
// Used by the port checker; needs signals clk and rst_n in scope.
`ifndef LED_BREATHE_GENERATOR_CORE_DEFINES_SVH
`define LED_BREATHE_GENERATOR_CORE_DEFINES_SVH

// antecedent holds -> consequent in the same cycle
`define LBG_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// antecedent holds -> consequent in the next cycle
`define LBG_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/lbg_pkg.sv =====
// Shared widths, codes and controller/datapath interface types
// for the breathing LED generator. No dependencies.
package lbg_pkg;

  // default parameter values
  localparam int NUM_LEDS_DEF     = 16;
  localparam int SINE_ENTRIES_DEF = 1024;
  // one tick drives at most this many LEDs
  localparam int MAX_OUT          = 16;

  // field widths
  localparam int PER_W      = 20;
  localparam int DT_W       = 16;
  localparam int LED_W      = 4;
  localparam int DLY_W      = 20;
  localparam int BRT_W      = 16;
  localparam int AMP_W      = 16;
  localparam int BIAS_W     = 17;
  localparam int USE_W      = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;

  // divider: dividend is a 21-bit sum, iteration count fits 5 bits
  localparam int SUM_W     = PER_W + 1;
  localparam int DIV_CNT_W = 5;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AMPLITUDE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BIAS      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LEDS      = 2'd3;

  // register reset values
  localparam logic [PER_W-1:0] PERIOD_RST = 20'd5000;
  localparam logic [AMP_W-1:0] AMP_RST    = 16'hFFFF;

  // input commands
  localparam logic CMD_TICK  = 1'b0;
  localparam logic CMD_DELAY = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic dly_wr;
    logic tick_start;
    logic phase_load;
    logic led_clr;
    logic led_inc;
    logic ang_start;
    logic ang_load;
    logic mul_load;
    logic idx_start;
    logic rom_rd;
    logic swing_load;
    logic out_load;
  } lbg_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic div_done;
    logic count_zero;
    logic last_led;
    logic out_free;
  } lbg_sts_t;

endpackage

// ===== rtl/lbg_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Depends on lbg_pkg for widths.
module lbg_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [lbg_pkg::PER_W-1:0]     divisor,
  input  logic [lbg_pkg::PER_W-1:0]     rem_init,
  input  logic [lbg_pkg::SUM_W-1:0]     dividend,
  input  logic [lbg_pkg::DIV_CNT_W-1:0] iters,
  output logic                          done,
  output logic [lbg_pkg::PER_W-1:0]     rem,
  output logic [lbg_pkg::SUM_W-1:0]     quo
);

  logic [lbg_pkg::PER_W-1:0]     rem_r, rem_nxt;
  logic [lbg_pkg::SUM_W-1:0]     sh_r, quo_r;
  logic [lbg_pkg::DIV_CNT_W-1:0] cnt_r;
  logic                          busy_r, done_r;
  logic [lbg_pkg::SUM_W-1:0]     trial;
  logic                          ge;

  // one step: shift in next dividend bit, subtract if it fits
  always_comb begin
    trial = {rem_r, sh_r[lbg_pkg::SUM_W-1]};
    ge    = (trial >= {1'b0, divisor});
    if (ge) begin
      rem_nxt = lbg_pkg::PER_W'(trial - {1'b0, divisor});
    end else begin
      rem_nxt = trial[lbg_pkg::PER_W-1:0];
    end
  end

  // control: busy while the iteration count runs down, then a done pulse
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= iters;
      end else if (busy_r) begin
        cnt_r <= cnt_r - lbg_pkg::DIV_CNT_W'(1);
        if (cnt_r == lbg_pkg::DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // data
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= rem_init;
      sh_r  <= dividend;
      quo_r <= '0;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      sh_r  <= {sh_r[lbg_pkg::SUM_W-2:0], 1'b0};
      quo_r <= {quo_r[lbg_pkg::SUM_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign rem  = rem_r;
  assign quo  = quo_r;

endmodule

// ===== rtl/lbg_sine_rom.sv =====
// Sine table, signed Q1.15, built at elaboration, registered read.
// No package dependency.
module lbg_sine_rom #(
  parameter int SINE_ENTRIES = 1024
) (
  input  logic                            clk,
  input  logic                            rd_en,
  input  logic [$clog2(SINE_ENTRIES)-1:0] addr,
  output logic signed [15:0]              data
);

  localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;
  localparam logic [63:0] ONE_Q30     = 64'd1073741824;

  // quadrant fold plus Q30 Taylor series to the x^11 term
  function automatic logic signed [15:0] sine_at(input int unsigned k);
    logic [63:0]        quad;
    logic [63:0]        r;
    logic [63:0]        m;
    logic [63:0]        x;
    logic [63:0]        term;
    logic [63:0]        s;
    logic [63:0]        v;
    logic signed [63:0] sum;
    quad = (64'(k) * 64'd4) / SINE_ENTRIES;
    r    = (64'(k) * 64'd4) % SINE_ENTRIES;
    m    = quad[0] ? (64'(SINE_ENTRIES) - r) : r;
    x    = (m * PI_HALF_Q30) / SINE_ENTRIES;
    term = x;
    sum  = $signed(x);
    term = ((((term * x) >> 30) * x) >> 30) / 6;
    sum  = sum - $signed(term);
    term = ((((term * x) >> 30) * x) >> 30) / 20;
    sum  = sum + $signed(term);
    term = ((((term * x) >> 30) * x) >> 30) / 42;
    sum  = sum - $signed(term);
    term = ((((term * x) >> 30) * x) >> 30) / 72;
    sum  = sum + $signed(term);
    term = ((((term * x) >> 30) * x) >> 30) / 110;
    sum  = sum - $signed(term);
    if (sum < 0) begin
      s = '0;
    end else if ($unsigned(sum) > ONE_Q30) begin
      s = ONE_Q30;
    end else begin
      s = $unsigned(sum);
    end
    v = (s * 64'd32767 + (ONE_Q30 >> 1)) >> 30;
    return quad[1] ? -$signed(16'(v)) : $signed(16'(v));
  endfunction

  logic signed [15:0] rom_w [SINE_ENTRIES];
  logic signed [15:0] data_r;

  for (genvar k = 0; k < SINE_ENTRIES; k++) begin : g_rom
    assign rom_w[k] = sine_at(k);
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      data_r <= rom_w[addr];
    end
  end

  assign data = data_r;

endmodule

// ===== rtl/lbg_dpath.sv =====
// Datapath: config registers, phase, delay table, divider, multipliers,
// sine ROM and output register. Depends on lbg_pkg, lbg_div, lbg_sine_rom.
module lbg_dpath #(
  parameter int NUM_LEDS     = lbg_pkg::NUM_LEDS_DEF,
  parameter int SINE_ENTRIES = lbg_pkg::SINE_ENTRIES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  lbg_pkg::lbg_cmd_t              cmd,
  output lbg_pkg::lbg_sts_t              sts,
  input  logic                           cfg_wr_en,
  input  logic [lbg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lbg_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic [lbg_pkg::DT_W-1:0]       in_dt_ms,
  input  logic [lbg_pkg::LED_W-1:0]      in_led_index,
  input  logic [lbg_pkg::DLY_W-1:0]      in_delay_ms,
  input  logic                           out_stall,
  output logic                           out_valid,
  output logic [lbg_pkg::LED_W-1:0]      out_led_number,
  output logic [lbg_pkg::BRT_W-1:0]      out_brightness,
  output logic                           out_last
);

  localparam int TBL_DEPTH = (NUM_LEDS < lbg_pkg::MAX_OUT) ? NUM_LEDS : lbg_pkg::MAX_OUT;
  localparam int TBL_AW    = (TBL_DEPTH > 1) ? $clog2(TBL_DEPTH) : 1;
  localparam int IDX_W     = $clog2(SINE_ENTRIES);
  localparam int SE_W      = $clog2(SINE_ENTRIES + 1);
  localparam int PROD_W    = lbg_pkg::PER_W + SE_W;
  localparam int BR_W      = 19;
  localparam int SW_W      = 2 * lbg_pkg::AMP_W;

  // configuration registers
  logic [lbg_pkg::PER_W-1:0]         period_r;
  logic [lbg_pkg::AMP_W-1:0]         amp_r;
  logic signed [lbg_pkg::BIAS_W-1:0] bias_r;
  logic [lbg_pkg::USE_W-1:0]         leds_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= lbg_pkg::PERIOD_RST;
      amp_r    <= lbg_pkg::AMP_RST;
      bias_r   <= '0;
      leds_r   <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        lbg_pkg::CFG_PERIOD:    period_r <= cfg_wdata[lbg_pkg::PER_W-1:0];
        lbg_pkg::CFG_AMPLITUDE: amp_r    <= cfg_wdata[lbg_pkg::AMP_W-1:0];
        lbg_pkg::CFG_BIAS:      bias_r   <= $signed(cfg_wdata[lbg_pkg::BIAS_W-1:0]);
        lbg_pkg::CFG_LEDS:      leds_r   <= cfg_wdata[lbg_pkg::USE_W-1:0];
      endcase
    end
  end

  // zero period behaves as one
  logic [lbg_pkg::PER_W-1:0] per_eff;
  assign per_eff = (period_r == '0) ? lbg_pkg::PER_W'(1) : period_r;

  // LEDs per tick, clamped to the table depth
  logic [lbg_pkg::USE_W-1:0] count;
  assign count = (leds_r > lbg_pkg::USE_W'(TBL_DEPTH)) ? lbg_pkg::USE_W'(TBL_DEPTH) : leds_r;

  // delay table, cleared at reset
  logic [lbg_pkg::DLY_W-1:0] dly_r [TBL_DEPTH];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TBL_DEPTH; i++) begin
        dly_r[i] <= '0;
      end
    end else if (cmd.dly_wr &&
                 (lbg_pkg::USE_W'(in_led_index) < lbg_pkg::USE_W'(TBL_DEPTH))) begin
      dly_r[in_led_index[TBL_AW-1:0]] <= in_delay_ms;
    end
  end

  // LED walk counter
  logic [lbg_pkg::LED_W-1:0] led_cnt_r;
  logic                      last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      led_cnt_r <= '0;
    end else if (cmd.led_clr) begin
      led_cnt_r <= '0;
    end else if (cmd.led_inc) begin
      led_cnt_r <= led_cnt_r + lbg_pkg::LED_W'(1);
    end
  end

  assign last = ((lbg_pkg::USE_W'(led_cnt_r) + lbg_pkg::USE_W'(1)) == count);

  // divider operand select
  logic [lbg_pkg::PER_W-1:0]     phase_r;
  logic [lbg_pkg::PER_W-1:0]     ang_r;
  logic [PROD_W-1:0]             prod_r;
  logic                          div_start;
  logic [lbg_pkg::PER_W-1:0]     div_rem_init;
  logic [lbg_pkg::SUM_W-1:0]     div_dividend;
  logic [lbg_pkg::DIV_CNT_W-1:0] div_iters;
  logic                          div_done;
  logic [lbg_pkg::PER_W-1:0]     div_rem;
  logic [lbg_pkg::SUM_W-1:0]     div_quo;

  assign div_start = cmd.tick_start | cmd.ang_start | cmd.idx_start;

  always_comb begin
    priority if (cmd.tick_start) begin
      // new phase = (phase + dt) mod period
      div_rem_init = '0;
      div_dividend = lbg_pkg::SUM_W'(phase_r) + lbg_pkg::SUM_W'(in_dt_ms);
      div_iters    = lbg_pkg::DIV_CNT_W'(lbg_pkg::SUM_W);
    end else if (cmd.ang_start) begin
      // angle = (phase + delay) mod period
      div_rem_init = '0;
      div_dividend = lbg_pkg::SUM_W'(phase_r) +
                     lbg_pkg::SUM_W'(dly_r[led_cnt_r[TBL_AW-1:0]]);
      div_iters    = lbg_pkg::DIV_CNT_W'(lbg_pkg::SUM_W);
    end else begin
      // index = angle * entries / period; upper product bits are already below period
      div_rem_init = prod_r[IDX_W +: lbg_pkg::PER_W];
      div_dividend = lbg_pkg::SUM_W'(prod_r[IDX_W-1:0]) << (lbg_pkg::SUM_W - IDX_W);
      div_iters    = lbg_pkg::DIV_CNT_W'(IDX_W);
    end
  end

  lbg_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .divisor  (per_eff),
    .rem_init (div_rem_init),
    .dividend (div_dividend),
    .iters    (div_iters),
    .done     (div_done),
    .rem      (div_rem),
    .quo      (div_quo)
  );

  // phase register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
    end else if (cmd.phase_load) begin
      phase_r <= div_rem;
    end
  end

  // angle and scaling product
  always_ff @(posedge clk) begin
    if (cmd.ang_load) begin
      ang_r <= div_rem;
    end
    if (cmd.mul_load) begin
      prod_r <= PROD_W'(ang_r) * PROD_W'(SINE_ENTRIES);
    end
  end

  // ROM address, guarded against the top entry
  logic [IDX_W-1:0]   rom_addr;
  logic signed [15:0] sine;

  assign rom_addr = (div_quo[IDX_W-1:0] > IDX_W'(SINE_ENTRIES - 1)) ?
                    IDX_W'(SINE_ENTRIES - 1) : div_quo[IDX_W-1:0];

  lbg_sine_rom #(
    .SINE_ENTRIES (SINE_ENTRIES)
  ) u_rom (
    .clk   (clk),
    .rd_en (cmd.rom_rd),
    .addr  (rom_addr),
    .data  (sine)
  );

  // swing product: amplitude * (32768 + sine); offset is a flip of the sign bit
  logic [lbg_pkg::AMP_W-1:0] sine_off;
  logic [SW_W-1:0]           sw_prod_r;

  assign sine_off = {~sine[15], sine[14:0]};

  always_ff @(posedge clk) begin
    if (cmd.swing_load) begin
      sw_prod_r <= SW_W'(amp_r) * SW_W'(sine_off);
    end
  end

  // round, add bias, saturate
  logic [16:0]            swing;
  logic signed [BR_W-1:0] br_sum;
  logic [lbg_pkg::BRT_W-1:0] br_sat;

  always_comb begin
    swing  = 17'(((SW_W + 1)'(sw_prod_r) + (SW_W + 1)'(32768)) >> 16);
    br_sum = BR_W'(bias_r) + $signed({2'b00, swing});
    if (br_sum < 0) begin
      br_sat = '0;
    end else if (br_sum > $signed(BR_W'(65535))) begin
      br_sat = '1;
    end else begin
      br_sat = br_sum[lbg_pkg::BRT_W-1:0];
    end
  end

  // output register
  logic                      out_valid_r, out_valid_nxt;
  logic [lbg_pkg::LED_W-1:0] out_led_r;
  logic [lbg_pkg::BRT_W-1:0] out_bright_r;
  logic                      out_last_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_led_r    <= led_cnt_r;
      out_bright_r <= br_sat;
      out_last_r   <= last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_led_number = out_led_r;
  assign out_brightness = out_bright_r;
  assign out_last       = out_last_r;

  // status
  assign sts.div_done   = div_done;
  assign sts.count_zero = (count == '0);
  assign sts.last_led   = last;
  assign sts.out_free   = !out_valid_r || !out_stall;

endmodule

// ===== rtl/lbg_ctrl.sv =====
// Controller state machine: sequences the phase update and the per-LED walk.
// Depends on lbg_pkg for the command and status types.
module lbg_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_command,
  input  lbg_pkg::lbg_sts_t sts,
  output logic              in_stall,
  output lbg_pkg::lbg_cmd_t cmd
);

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_PH_DIV    = 4'd1;
  localparam logic [3:0] S_ANG_START = 4'd2;
  localparam logic [3:0] S_ANG_DIV   = 4'd3;
  localparam logic [3:0] S_MUL       = 4'd4;
  localparam logic [3:0] S_IDX_START = 4'd5;
  localparam logic [3:0] S_IDX_DIV   = 4'd6;
  localparam logic [3:0] S_SWING     = 4'd7;
  localparam logic [3:0] S_OUT       = 4'd8;

  logic [3:0] state_r, state_nxt;
  logic       acc;

  assign in_stall = (state_r != S_IDLE);
  assign acc      = in_valid && !in_stall;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (acc) begin
          if (in_command == lbg_pkg::CMD_DELAY) begin
            cmd.dly_wr = 1'b1;
          end else begin
            cmd.tick_start = 1'b1;
            state_nxt      = S_PH_DIV;
          end
        end
      end
      S_PH_DIV: begin
        if (sts.div_done) begin
          cmd.phase_load = 1'b1;
          cmd.led_clr    = 1'b1;
          state_nxt      = sts.count_zero ? S_IDLE : S_ANG_START;
        end
      end
      S_ANG_START: begin
        cmd.ang_start = 1'b1;
        state_nxt     = S_ANG_DIV;
      end
      S_ANG_DIV: begin
        if (sts.div_done) begin
          cmd.ang_load = 1'b1;
          state_nxt    = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul_load = 1'b1;
        state_nxt    = S_IDX_START;
      end
      S_IDX_START: begin
        cmd.idx_start = 1'b1;
        state_nxt     = S_IDX_DIV;
      end
      S_IDX_DIV: begin
        if (sts.div_done) begin
          cmd.rom_rd = 1'b1;
          state_nxt  = S_SWING;
        end
      end
      S_SWING: begin
        cmd.swing_load = 1'b1;
        state_nxt      = S_OUT;
      end
      S_OUT: begin
        // wait for the output register to free up
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          if (sts.last_led) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.led_inc = 1'b1;
            state_nxt   = S_ANG_START;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/led_breathe_generator_core.sv =====
// Breathing LED brightness generator, top level. A delay write leaves the block idle.
// A tick runs bit-serial divisions (phase once, then angle and ROM index for each LED
// in use) through one shared divider.
// One item at a time; the output register lets the next LED compute while a result waits.
// Synchronous active-low reset: registers to defaults, phase and all delays to zero.
module led_breathe_generator_core #(
  parameter int NUM_LEDS     = lbg_pkg::NUM_LEDS_DEF,
  parameter int SINE_ENTRIES = lbg_pkg::SINE_ENTRIES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [lbg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lbg_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_command,
  input  logic [lbg_pkg::DT_W-1:0]       in_dt_ms,
  input  logic [lbg_pkg::LED_W-1:0]      in_led_index,
  input  logic [lbg_pkg::DLY_W-1:0]      in_delay_ms,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [lbg_pkg::LED_W-1:0]      out_led_number,
  output logic [lbg_pkg::BRT_W-1:0]      out_brightness,
  output logic                           out_last
);

  lbg_pkg::lbg_cmd_t cmd;
  lbg_pkg::lbg_sts_t sts;

  lbg_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_command),
    .sts        (sts),
    .in_stall   (in_stall),
    .cmd        (cmd)
  );

  lbg_dpath #(
    .NUM_LEDS     (NUM_LEDS),
    .SINE_ENTRIES (SINE_ENTRIES)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_dt_ms       (in_dt_ms),
    .in_led_index   (in_led_index),
    .in_delay_ms    (in_delay_ms),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .out_led_number (out_led_number),
    .out_brightness (out_brightness),
    .out_last       (out_last)
  );

endmodule

// ===== rtl/lbg_checker.sv =====
// Port-level checks for the breathing LED generator, bound to the top level.
// Depends on lbg_pkg and led_breathe_generator_core_defines.svh.
`include "led_breathe_generator_core_defines.svh"

module lbg_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           cfg_wr_en,
  input logic [lbg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input logic [lbg_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic                           in_command,
  input logic [lbg_pkg::DT_W-1:0]       in_dt_ms,
  input logic [lbg_pkg::LED_W-1:0]      in_led_index,
  input logic [lbg_pkg::DLY_W-1:0]      in_delay_ms,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [lbg_pkg::LED_W-1:0]      out_led_number,
  input logic [lbg_pkg::BRT_W-1:0]      out_brightness,
  input logic                           out_last
);

  // stalled result holds
  `LBG_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_led_number) && $stable(out_brightness) && $stable(out_last), "stalled result changed")

  // a tick transfer makes the block busy
  `LBG_ASSERT_NXT(a_tick_busy, in_valid && !in_stall && (in_command == lbg_pkg::CMD_TICK), in_stall, "tick accepted but input not stalled")

  // a delay write leaves the input ready in the next cycle
  `LBG_ASSERT_NXT(a_wr_ready, in_valid && !in_stall && (in_command == lbg_pkg::CMD_DELAY), !in_stall, "delay write left block busy")

  // a result that is not the last of its tick means the tick is still running
  `LBG_ASSERT_IMP(a_mid_busy, out_valid && !out_last, in_stall, "input ready before tick finished")

endmodule

bind led_breathe_generator_core lbg_checker u_lbg_checker (.*);

// ===== bench/tb_led_breathe_generator_core.sv =====
// Self-checking bench for led_breathe_generator_core: a directed table, then random phases.
// An in-bench predictor of phase, delay table and registers computes every brightness.
// Depends on lbg_pkg and the core RTL.
`timescale 1ns / 100ps

module tb_led_breathe_generator_core;
  import lbg_pkg::*;

  localparam int NLED          = NUM_LEDS_DEF;
  localparam int SINE_N        = SINE_ENTRIES_DEF;
  localparam int ITEM_TARGET   = 280;
  localparam int SETTLE_CYCLES = 800;      // outlasts the longest tick
  localparam int HOLD_CYCLES   = 3000;
  localparam int CYCLE_LIMIT   = 1500000;
  localparam int PLAN_LEN      = 41;
  localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;
  localparam longint unsigned ONE_Q30     = 64'd1073741824;

  typedef struct packed {
    logic              cmd;
    logic [DT_W-1:0]   dt;
    logic [LED_W-1:0]  led;
    logic [DLY_W-1:0]  dly;
  } cmd_item_t;

  typedef struct packed {
    logic [LED_W-1:0]  led;
    logic [BRT_W-1:0]  brt;
    logic              last;
  } led_result_t;

  typedef enum logic {ROW_REG, ROW_ITEM} row_kind_e;

  // one directed step: a register write or an input transfer
  typedef struct packed {
    row_kind_e              kind;
    logic [CFG_IDX_W-1:0]   reg_idx;
    logic [CFG_DATA_W-1:0]  value;
    cmd_item_t              item;
    logic                   known;   // brightness of every LED is read off directly
    logic [BRT_W-1:0]       brt;
  } plan_row_t;

  localparam cmd_item_t NO_ITEM = '0;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_PERIOD;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_command = CMD_TICK;
  logic [DT_W-1:0] in_dt_ms = '0;
  logic [LED_W-1:0] in_led_index = '0;
  logic [DLY_W-1:0] in_delay_ms = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [LED_W-1:0] out_led_number;
  logic [BRT_W-1:0] out_brightness;
  logic out_last;

  // predictor state
  logic [PER_W-1:0]         period_reg = PERIOD_RST;
  logic [AMP_W-1:0]         amp_reg = AMP_RST;
  logic signed [BIAS_W-1:0] bias_reg = '0;
  logic [USE_W-1:0]         leds_reg = '0;
  logic [PER_W-1:0]         phase_reg = '0;
  logic [DLY_W-1:0]         delay_tbl [NLED];
  int                       sine_tab [SINE_N];

  led_result_t brightness_q [$];
  int  mismatches = 0;
  int  sent = 0;
  int  cycles = 0;
  int  tx_idle_pct = 35;
  int  rx_idle_pct = 80;
  bit  hold_req = 1'b0;

  plan_row_t plan [PLAN_LEN] = '{
    // after reset no LEDs are in use: no result; unused fields carry junk
    '{ROW_ITEM, CFG_PERIOD,    20'd0,      '{CMD_TICK,  16'd0,     4'd9,  20'h12345}, 1'b0, 16'd0},
    '{ROW_ITEM, CFG_PERIOD,    20'd0,      '{CMD_DELAY, 16'hFFFF,  4'd0,  20'hFFFFF}, 1'b0, 16'd0},
    '{ROW_ITEM, CFG_PERIOD,    20'd0,      '{CMD_DELAY, 16'd1234,  4'd15, 20'd0},     1'b0, 16'd0},
    // period of one: angle always zero, sine zero, half scale
    '{ROW_REG,  CFG_PERIOD,    20'd1,      NO_ITEM, 1'b0, 16'd0},
    '{ROW_REG,  CFG_LEDS,      20'd16,     NO_ITEM, 1'b0, 16'd0},
    '{ROW_ITEM, CFG_PERIOD,    20'd0,      '{CMD_TICK,  16'hFFFF,  4'd0,  20'd0},     1'b1, 16'd32768},
    // zero period behaves as a period of one
    '{ROW_REG,  CFG_PERIOD,    20'd0,      NO_ITEM, 1'b0, 16'd0},
    '{ROW_ITEM, CFG_PERIOD,    20'd0,      '{CMD_TICK,  16'd12345, 4'd5,  20'hABCDE}, 1'b1, 16'd32768},
    // a bias of -65535 pins everything at zero
    '{ROW_REG,  CFG_BIAS,      20'h10001,  NO_ITEM, 1'b0, 16'd0},
    '{ROW_REG,  CFG_PERIOD,    20'd1000000, NO_ITEM, 1'b0, 16'd0},
    '{ROW_ITEM, CFG_PERIOD,    20'd0,      '{CMD_TICK,  16'hFFFF,  4'd0,  20'd0},     1'b1, 16'd0},
    // full positive bias saturates high, with and without swing
    '{ROW_REG,  CFG_BIAS,      20'h0FFFF,  NO_ITEM, 1'b0, 16'd0},
    '{ROW_REG,  CFG_AMPLITUDE, 20'd0,      NO_ITEM, 1'b0, 16'd0},
    '{ROW_ITEM, CFG_PERIOD,    20'd0,      '{CMD_TICK,  16'd1,     4'd0,  20'd0},     1'b1, 16'd65535},
    '{ROW_REG,  CFG_AMPLITUDE, 20'hFFFFF,  NO_ITEM, 1'b0, 16'd0},
    '{ROW_ITEM, CFG_PERIOD,    20'd0,      '{CMD_TICK,  16'd500,   4'd0,  20'd0},     1'b1, 16'd65535},
    // over-range LED count clamps to all sixteen; widest period
    '{ROW_REG,  CFG_BIAS,      20'd0,      NO_ITEM, 1'b0, 16'd0},
    '{ROW_REG,  CFG_LEDS,      20'd31,     NO_ITEM, 1'b0, 16'd0},
    '{ROW_REG,  CFG_PERIOD,    20'hFFFFF,  NO_ITEM, 1'b0, 16'd0},
    '{ROW_ITEM, CFG_PERIOD,    20'd0,      '{CMD_DELAY, 16'd7,     4'd1,  20'd262144},  1'b0, 16'd0},
    '{ROW_ITEM, CFG_PERIOD,    20'd0,      '{CMD_DELAY, 16'd0,     4'd2,  20'd524288},  1'b0, 16'd0},
    '{ROW_ITEM, CFG_PERIOD,    20'd0,      '{CMD_DELAY, 16'd0,     4'd3,  20'd786432},  1'b0, 16'd0},
    '{ROW_ITEM, CFG_PERIOD,    20'd0,      '{CMD_DELAY, 16'h5555,  4'd7,  20'hAAAAA},   1'b0, 16'd0},
    '{ROW_ITEM, CFG_PERIOD,    20'd0,      '{CMD_DELAY, 16'hAAAA,  4'd8,  20'h55555},   1'b0, 16'd0},
    '{ROW_ITEM, CFG_PERIOD,    20'd0,      '{CMD_DELAY, 16'd0,     4'd15, 20'd1000000}, 1'b0, 16'd0},
    '{ROW_ITEM, CFG_PERIOD,    20'd0,      '{CMD_TICK,  16'd0,     4'd0,  20'd0},     1'b0, 16'd0},
    '{ROW_ITEM, CFG_PERIOD,    20'd0,      '{CMD_TICK,  16'hFFFF,  4'd0,  20'd0},     1'b0, 16'd0},
    // phase now sits beyond the shorter period; a single LED gets last
    '{ROW_REG,  CFG_PERIOD,    20'd5000,   NO_ITEM, 1'b0, 16'd0},
    '{ROW_REG,  CFG_LEDS,      20'd1,      NO_ITEM, 1'b0, 16'd0},
    '{ROW_ITEM, CFG_PERIOD,    20'd0,      '{CMD_TICK,  16'd1250,  4'd0,  20'd0},     1'b0, 16'd0},
    '{ROW_ITEM, CFG_PERIOD,    20'd0,      '{CMD_TICK,  16'd2500,  4'd0,  20'd0},     1'b0, 16'd0},
    // tiny period walks every quadrant
    '{ROW_REG,  CFG_PERIOD,    20'd4,      NO_ITEM, 1'b0, 16'd0},
    '{ROW_REG,  CFG_LEDS,      20'd5,      NO_ITEM, 1'b0, 16'd0},
    '{ROW_ITEM, CFG_PERIOD,    20'd0,      '{CMD_TICK,  16'd1,     4'd0,  20'd0},     1'b0, 16'd0},
    '{ROW_ITEM, CFG_PERIOD,    20'd0,      '{CMD_TICK,  16'd1,     4'd0,  20'd0},     1'b0, 16'd0},
    '{ROW_ITEM, CFG_PERIOD,    20'd0,      '{CMD_TICK,  16'd1,     4'd0,  20'd0},     1'b0, 16'd0},
    '{ROW_ITEM, CFG_PERIOD,    20'd0,      '{CMD_TICK,  16'd1,     4'd0,  20'd0},     1'b0, 16'd0},
    // no LEDs: the phase still moves, seen on the next tick
    '{ROW_REG,  CFG_LEDS,      20'd0,      NO_ITEM, 1'b0, 16'd0},
    '{ROW_ITEM, CFG_PERIOD,    20'd0,      '{CMD_TICK,  16'd777,   4'd0,  20'd0},     1'b0, 16'd0},
    '{ROW_REG,  CFG_LEDS,      20'd3,      NO_ITEM, 1'b0, 16'd0},
    '{ROW_ITEM, CFG_PERIOD,    20'd0,      '{CMD_TICK,  16'd0,     4'd0,  20'd0},     1'b0, 16'd0}
  };

  led_breathe_generator_core dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_command     (in_command),
    .in_dt_ms       (in_dt_ms),
    .in_led_index   (in_led_index),
    .in_delay_ms    (in_delay_ms),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_led_number (out_led_number),
    .out_brightness (out_brightness),
    .out_last       (out_last)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic void log_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endfunction

  // advance the phase or store a delay; queue the brightness of every LED in use
  task automatic predict_brightness(input cmd_item_t it, input logic known,
                                    input logic [BRT_W-1:0] known_brt);
    longint unsigned per, ang, ri;
    longint swing, lvl;
    int count;
    led_result_t r;
    if (it.cmd == CMD_DELAY) begin
      delay_tbl[it.led] = it.dly;
    end else begin
      per = (period_reg == '0) ? 1 : period_reg;
      ang = (phase_reg + it.dt) % per;
      phase_reg = ang[PER_W-1:0];
      count = (leds_reg > NLED) ? NLED : leds_reg;
      if (count > MAX_OUT) count = MAX_OUT;
      for (int i = 0; i < count; i++) begin
        ang = (phase_reg + delay_tbl[i]) % per;
        ri = ang * SINE_N / per;
        if (ri >= SINE_N) ri = SINE_N - 1;
        swing = (longint'(amp_reg) * (32768 + sine_tab[ri]) + 32768) >>> 16;
        lvl = longint'(bias_reg) + swing;
        if (lvl < 0) lvl = 0;
        if (lvl > 65535) lvl = 65535;
        r.led  = 4'(i);
        r.brt  = known ? known_brt : lvl[BRT_W-1:0];
        r.last = (i == count - 1);
        brightness_q.push_back(r);
      end
    end
  endtask

  // register write while the core is idle; the predictor copy follows at once
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      CFG_PERIOD:    period_reg = data[PER_W-1:0];
      CFG_AMPLITUDE: amp_reg = data[AMP_W-1:0];
      CFG_BIAS:      bias_reg = data[BIAS_W-1:0];
      CFG_LEDS:      leds_reg = data[USE_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // offer one item, hold it until the transfer, then predict its results
  task automatic send_item(input cmd_item_t it, input logic known,
                           input logic [BRT_W-1:0] known_brt);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_command   <= it.cmd;
    in_dt_ms     <= it.dt;
    in_led_index <= it.led;
    in_delay_ms  <= it.dly;
    do @(posedge clk); while (in_stall);
    predict_brightness(it, known, known_brt);
    sent++;
    if (sent < 95) begin
      tx_idle_pct = 35;
      rx_idle_pct = 80;
    end else if (sent < 190) begin
      tx_idle_pct = 80;
      rx_idle_pct = 35;
    end else begin
      tx_idle_pct = 0;
      rx_idle_pct = 0;
    end
  endtask

  // stop sending, wait for every queued brightness, then let a zero-LED tick finish
  task automatic settle_block();
    in_valid <= 1'b0;
    while (brightness_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // receiver: random stalls, plus one long hold-off on request
  initial begin : result_stall
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  // compare every result transfer with the oldest expectation
  always @(posedge clk) begin : result_check
    led_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (brightness_q.size() == 0) begin
        log_mismatch($sformatf("%0t: unexpected result led %0d brightness %0d last %0b",
                               $time, out_led_number, out_brightness, out_last));
      end else begin
        want = brightness_q.pop_front();
        if (out_led_number !== want.led || out_brightness !== want.brt ||
            out_last !== want.last)
          log_mismatch($sformatf("%0t: expected led %0d brightness %0d last %0b, got %0d %0d %0b",
                                 $time, want.led, want.brt, want.last,
                                 out_led_number, out_brightness, out_last));
      end
    end
  end

  initial begin : watchdog
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("== FAIL ==");
    $finish;
  end

  initial begin : stimulus
    cmd_item_t        it;
    logic [PER_W-1:0] per_w;
    logic [AMP_W-1:0] amp_w;
    logic [BIAS_W-1:0] bias_w;
    logic [USE_W-1:0] leds_w;
    longint unsigned  x, term, m, s;
    longint           qsum;
    int               quad, rem, v;
    bit               busy;
    bit               hold_done;

    // sine table: Q30 Taylor series on a quarter wave, folded, rounded to Q1.15
    for (int k = 0; k < SINE_N; k++) begin
      quad = (4 * k) / SINE_N;
      rem  = (4 * k) % SINE_N;
      m    = (quad & 1) ? SINE_N - rem : rem;
      x    = (m * PI_HALF_Q30) / SINE_N;
      term = x;
      qsum = longint'(x);
      for (int n = 1; n <= 5; n++) begin
        term = (term * x) >> 30;
        term = (term * x) >> 30;
        term = term / (2 * n * (2 * n + 1));
        if (n & 1) qsum = qsum - longint'(term);
        else qsum = qsum + longint'(term);
      end
      if (qsum < 0) qsum = 0;
      if (qsum > longint'(ONE_Q30)) qsum = longint'(ONE_Q30);
      s = qsum;
      v = int'((s * 32767 + (ONE_Q30 >> 1)) >> 30);
      sine_tab[k] = (quad & 2) ? -v : v;
    end
    for (int i = 0; i < NLED; i++) delay_tbl[i] = '0;

    busy = 1'b0;
    hold_done = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed table
    for (int r = 0; r < PLAN_LEN; r++) begin
      if (plan[r].kind == ROW_REG) begin
        if (busy) begin
          settle_block();
          busy = 1'b0;
        end
        write_reg(plan[r].reg_idx, plan[r].value);
      end else begin
        send_item(plan[r].item, plan[r].known, plan[r].brt);
        busy = 1'b1;
      end
    end

    // random phases: fresh registers, then a burst of items
    while (sent < ITEM_TARGET) begin
      settle_block();
      case ($urandom_range(5))
        0: per_w = '0;
        1: per_w = 20'd1;
        2: per_w = 20'hFFFFF;
        3: per_w = 20'($urandom_range(2, 64));
        4: per_w = 20'($urandom_range(1, 1000000));
        default: per_w = 20'($urandom_range(100, 20000));
      endcase
      case ($urandom_range(3))
        0: amp_w = '0;
        1: amp_w = 16'hFFFF;
        default: amp_w = 16'($urandom);
      endcase
      case ($urandom_range(5))
        0: bias_w = 17'h10000;
        1: bias_w = 17'h10001;
        2: bias_w = 17'h0FFFF;
        3: bias_w = '0;
        default: bias_w = 17'($urandom);
      endcase
      if ($urandom_range(99) < 75) leds_w = 5'($urandom_range(1, 16));
      else leds_w = 5'($urandom_range(0, 31));
      // the long hold-off wants a full set of LEDs to back the core up
      if (!hold_done && sent >= 200) leds_w = 5'd16;
      write_reg(CFG_PERIOD, per_w);
      write_reg(CFG_AMPLITUDE, {4'($urandom), amp_w});
      write_reg(CFG_BIAS, {3'($urandom), bias_w});
      write_reg(CFG_LEDS, {15'($urandom), leds_w});
      if (!hold_done && sent >= 200) begin
        hold_req = 1'b1;
        hold_done = 1'b1;
      end
      repeat ($urandom_range(15, 35)) begin
        it.cmd = ($urandom_range(99) < 65) ? CMD_TICK : CMD_DELAY;
        it.led = 4'($urandom);
        case ($urandom_range(3))
          0: it.dt = 16'($urandom_range(0, 50));
          1: it.dt = 16'hFFFF;
          default: it.dt = 16'($urandom);
        endcase
        case ($urandom_range(4))
          0: it.dly = 20'hFFFFF;
          1: it.dly = '0;
          2: it.dly = 20'($urandom_range(0, per_w));
          default: it.dly = 20'($urandom);
        endcase
        send_item(it, 1'b0, '0);
      end
    end

    settle_block();
    if (mismatches == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
